// ===== hdl/b64d_pkg.sv =====
// Shared types, constants and the character map for the Base64 stream decoder.
`default_nettype none
package b64d_pkg;

  localparam int DEFAULT_COUNT_BITS = 16;
  localparam int BYTE_COUNT_BITS    = 16;
  localparam int QUEUE_DEPTH        = 4;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_END_OK   = 2'd1,
    KIND_BAD_LEN  = 2'd2,
    KIND_BAD_CHAR = 2'd3
  } kind_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  // One queue entry: the data bytes of a finished group and an optional end beat.
  typedef struct packed {
    logic [2:0][7:0]            bytes;   // bytes[0] goes out first
    logic [1:0]                 nbytes;
    logic                       has_end;
    kind_t                      kind;
    logic [BYTE_COUNT_BITS-1:0] count;
  } cmd_t;

  function automatic sextet_t decode_sextet(input logic [7:0] c);
    sextet_t r;
    r.ok  = 1'b1;
    r.val = '0;
    case (c) inside
      [8'h41:8'h5A]: r.val = 6'(c - 8'h41);
      [8'h61:8'h7A]: r.val = 6'(c - 8'h61 + 8'd26);
      [8'h30:8'h39]: r.val = 6'(c - 8'h30 + 8'd52);
      8'h2B:         r.val = 6'd62;
      8'h2F:         r.val = 6'd63;
      default:       r.ok  = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/b64d_in_if.sv =====
// Character channel: one encoded character and a last-of-message flag per beat.
`default_nettype none
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, in_char, in_last, input ready);
  modport sink   (input valid, in_char, in_last, output ready);
endinterface
`default_nettype wire

// ===== hdl/b64d_out_if.sv =====
// Result channel: a decoded byte or an end-of-message status per beat.
`default_nettype none
interface b64d_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  kind;
  logic [15:0] byte_count;
  logic        run_end;

  modport source (output valid, out_byte, kind, byte_count, run_end, input ready);
  modport sink   (input valid, out_byte, kind, byte_count, run_end, output ready);
endinterface
`default_nettype wire

// ===== hdl/b64d_queue.sv =====
// Small command queue between the decode front and the result back end.
`default_nettype none
module b64d_queue
  import b64d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      empty
);
  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  cmd_t                mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   fill;

  assign full     = (fill == (PTR_BITS+1)'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/b64d_front.sv =====
// Decode front: takes characters, tracks group state, queues result commands.
`default_nettype none
module b64d_front
  import b64d_pkg::*;
#(
  parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
  input  wire logic clk,
  input  wire logic rst,
  b64d_in_if.sink   chars,
  input  wire logic q_full,
  output logic      push,
  output cmd_t      push_data
);
  localparam int WIDE_BITS = (COUNT_BITS > BYTE_COUNT_BITS) ? COUNT_BITS : BYTE_COUNT_BITS;

  logic [17:0]           held;
  logic [1:0]            pos;
  logic                  stopped;
  logic                  bad_seen;
  logic                  third_absent;
  logic [COUNT_BITS-1:0] total;

  logic [17:0]           held_next;
  logic [1:0]            pos_next;
  logic                  stopped_next;
  logic                  bad_seen_next;
  logic                  third_absent_next;
  logic [COUNT_BITS-1:0] total_next;

  sextet_t               sx;
  logic [5:0]            h0, h1, h2;
  logic [1:0]            nbytes;
  logic [COUNT_BITS:0]   sum;
  logic [WIDE_BITS-1:0]  total_wide;
  logic                  fire;

  assign chars.ready = !q_full;
  assign fire        = chars.valid && chars.ready;
  assign sx          = decode_sextet(chars.in_char);
  assign h0          = held[17:12];
  assign h1          = held[11:6];
  assign h2          = held[5:0];

  always_comb begin
    held_next         = held;
    stopped_next      = stopped;
    bad_seen_next     = bad_seen;
    third_absent_next = third_absent;
    nbytes            = 2'd0;

    if (!stopped) begin
      case (pos)
        2'd0: begin
          if (!sx.ok) begin
            bad_seen_next = 1'b1;
            stopped_next  = 1'b1;
          end else begin
            held_next = {sx.val, 12'd0};
          end
        end
        2'd1: begin
          if (!sx.ok) begin
            bad_seen_next = 1'b1;
            stopped_next  = 1'b1;
          end else begin
            held_next = {held[17:12], sx.val, 6'd0};
          end
        end
        2'd2: begin
          if (!sx.ok) begin
            third_absent_next = 1'b1;
          end else begin
            third_absent_next = 1'b0;
            held_next         = {held[17:6], sx.val};
          end
        end
        default: begin
          // group complete: a non-alphabet character in the third or fourth slot ends decoding
          if (third_absent) begin
            nbytes       = 2'd1;
            stopped_next = 1'b1;
          end else if (!sx.ok) begin
            nbytes       = 2'd2;
            stopped_next = 1'b1;
          end else begin
            nbytes = 2'd3;
          end
          held_next         = '0;
          third_absent_next = 1'b0;
        end
      endcase
    end

    pos_next   = pos + 2'd1;
    sum        = {1'b0, total} + (COUNT_BITS+1)'(nbytes);
    total_next = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    total_wide = WIDE_BITS'(total_next);

    push_data.bytes[0] = {h0, h1[5:4]};
    push_data.bytes[1] = {h1[3:0], h2[5:2]};
    push_data.bytes[2] = {h2[1:0], sx.val};
    push_data.nbytes   = nbytes;
    push_data.has_end  = chars.in_last;
    if (pos_next != 2'd0) begin
      push_data.kind = KIND_BAD_LEN;
    end else if (bad_seen_next) begin
      push_data.kind = KIND_BAD_CHAR;
    end else begin
      push_data.kind = KIND_END_OK;
    end
    push_data.count = (total_wide > WIDE_BITS'({BYTE_COUNT_BITS{1'b1}}))
                      ? {BYTE_COUNT_BITS{1'b1}} : total_wide[BYTE_COUNT_BITS-1:0];

    push = fire && ((nbytes != 2'd0) || chars.in_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held         <= '0;
      pos          <= '0;
      stopped      <= 1'b0;
      bad_seen     <= 1'b0;
      third_absent <= 1'b0;
      total        <= '0;
    end else if (fire) begin
      if (chars.in_last) begin
        held         <= '0;
        pos          <= '0;
        stopped      <= 1'b0;
        bad_seen     <= 1'b0;
        third_absent <= 1'b0;
        total        <= '0;
      end else begin
        held         <= held_next;
        pos          <= pos_next;
        stopped      <= stopped_next;
        bad_seen     <= bad_seen_next;
        third_absent <= third_absent_next;
        total        <= total_next;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/b64d_back.sv =====
// Result back end: expands queued commands into result beats, one per cycle unless the result side stalls.
`default_nettype none
module b64d_back
  import b64d_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_empty,
  input  wire cmd_t  q_data,
  output logic       pop,
  b64d_out_if.source results
);
  cmd_t       cur;
  logic       cur_valid;
  logic [1:0] idx;

  logic       step;
  logic       is_data;
  logic       done;
  logic       load;

  always_comb begin
    step    = cur_valid && (!results.valid || results.ready);
    is_data = (idx < cur.nbytes);
    done    = is_data ? ((idx == cur.nbytes - 2'd1) && !cur.has_end) : 1'b1;
    load    = (!cur_valid || (step && done));
    pop     = load && !q_empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (step && done) begin
      cur_valid <= 1'b0;
    end else if (step) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (step) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      results.run_end <= done;
      if (is_data) begin
        results.out_byte   <= cur.bytes[idx];
        results.kind       <= KIND_DATA;
        results.byte_count <= '0;
      end else begin
        results.out_byte   <= '0;
        results.kind       <= cur.kind;
        results.byte_count <= cur.count;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/base64_stream_decoder_unit.sv =====
// Top level of the Base64 stream decoder: front, command queue and back end.
//
//   channel   role   beat contents
//   -------   ----   ---------------------------------------------------
//   chars     sink   in_char (8), in_last (1)
//   results   source out_byte (8), kind (2), byte_count (16), run_end (1)
//
// Cycles: one character per cycle while the command queue has room. A
//   completed group gives up to three byte beats and the last character one
//   end beat; the back end sends one beat per cycle while results.ready holds,
//   so its output register sets the steady rate (four characters: at most four beats).
// Path: queue entry, back-end cur register, then the registered result output.
// Reset: rst, synchronous; clears group state, count, queue and output valid.
// Stalls: a stalled result side fills the four-entry queue; then chars.ready drops.
`default_nettype none
module base64_stream_decoder_unit
  import b64d_pkg::*;
#(
  parameter int COUNT_BITS = DEFAULT_COUNT_BITS   // width of the saturating byte total
) (
  input  wire logic   clk,
  input  wire logic   rst,
  b64d_in_if.sink     chars,
  b64d_out_if.source  results
);
  // front -> queue
  logic q_push;
  cmd_t q_push_data;
  logic q_full;
  // queue -> back
  logic q_pop;
  cmd_t q_pop_data;
  logic q_empty;

  b64d_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  b64d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  b64d_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_pop_data),
    .pop      (q_pop),
    .results  (results)
  );

  // front never writes a full queue
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("command pushed into full queue");

  // back never reads an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  // an end beat always closes the run of its character
  assert property (@(posedge clk) disable iff (rst)
    (results.valid && (results.kind != KIND_DATA)) |-> results.run_end)
    else $error("end beat without run_end");

  // a character the queue refused is one the front did not push
  assert property (@(posedge clk) disable iff (rst)
    (chars.valid && !chars.ready) |-> !q_push)
    else $error("push without accepted character");
endmodule
`default_nettype wire
